// ===== src/sbq_pkg.sv =====
// ---------------------------------------------------------------------------
// sbq_pkg: shared definitions for the shared block queue manager
// Word layouts, action and status codes, and parameter defaults.
// ---------------------------------------------------------------------------
package sbq_pkg;

  localparam int DEF_QUEUES     = 16;
  localparam int DEF_BLOCKS     = 256;
  localparam int DEF_BLOCK_SIZE = 64;

  localparam logic [1:0] ACT_PUT     = 2'd0;
  localparam logic [1:0] ACT_DRAIN   = 2'd1;
  localparam logic [1:0] ACT_QUOTA   = 2'd2;
  localparam logic [1:0] ACT_CLEANUP = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_QUOTA   = 3'd1;
  localparam logic [2:0] ST_NOBLK   = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  queue;
    logic [7:0]  data_byte;
    logic        msg_start;
    logic [15:0] message_len;
    logic [15:0] quota_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        queue_now_empty;
    logic [14:0] buffered_bytes;
    logic [8:0]  free_blocks;
  } out_t;

endpackage

// ===== src/shared_block_queue_manager_top.sv =====
// ---------------------------------------------------------------------------
// shared_block_queue_manager_top: byte queues on a shared block pool
// Per-queue FIFOs built from linked blocks, with whole-message admission.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_stall  | in_t: action, queue, byte, msg
//   out     | output    | out_valid/out_stall| out_t: status, byte, counts
//
// Each word passes through the accept cycle and the descriptor read, then
// a further step for an appended byte (block link read) or a drain (byte
// read). The descriptor memory read latency and the single link port
// set this.
// After reset a clearing pass over max(BLOCKS, QUEUES) entries builds the
// free list; no word is taken meanwhile. A stalled result holds the block
// in its final step. BLOCK_SIZE must be a power of two.
// ---------------------------------------------------------------------------
module shared_block_queue_manager_top import sbq_pkg::*; #(
  parameter int QUEUES     = DEF_QUEUES,
  parameter int BLOCKS     = DEF_BLOCKS,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic clk,
  input  logic rst,
  input  in_t  in_data,
  input  logic in_valid,
  output logic in_stall,
  output out_t out_data,
  output logic out_valid,
  input  logic out_stall
);

  localparam int QIW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int BW      = $clog2(BLOCKS);
  localparam int OW      = $clog2(BLOCK_SIZE);
  localparam int CW      = $clog2(BLOCKS + 1);
  localparam int CLR_LEN = (BLOCKS > QUEUES) ? BLOCKS : QUEUES;
  localparam int CLRW    = $clog2(CLR_LEN);

  typedef struct packed {
    logic [BW-1:0] head;
    logic [BW-1:0] tail;
    logic [OW-1:0] offset;
    logic [14:0]   bytes;
    logic [15:0]   quota;
  } desc_t;

  localparam int DSW = $bits(desc_t);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DESC   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;

  logic [2:0]      state, state_next;
  logic [CLRW-1:0] clr_cnt;
  in_t             item;
  logic [BW-1:0]   free_head, free_head_next;
  logic [CW-1:0]   free_count, free_count_next;
  logic [CW-1:0]   msg_reserved, msg_reserved_next;
  logic [15:0]     msg_left, msg_left_next;
  logic            msg_accepted, msg_accepted_next;
  logic [3:0]      msg_queue, msg_queue_next;

  // Memory ports.
  logic            d_we;
  logic [QIW-1:0]  d_waddr, d_raddr;
  desc_t           d_wdata, d_rdata;
  logic [DSW-1:0]  d_rbits;
  logic            l_we;
  logic [BW-1:0]   l_waddr, l_wdata, l_raddr, l_raddr_q, l_rdata;
  logic            b_we;
  logic [BW+OW-1:0] b_waddr, b_raddr, b_raddr_q;
  logic [7:0]      b_rdata;

  logic            out_free, finish;
  out_t            res;

  logic [QIW-1:0]  q_idx;
  logic            q_ok;
  desc_t           d;
  logic [OW-1:0]   pos;
  logic [OW:0]     rest;
  logic [16:0]     len_sum, rem;
  logic [17:0]     need;
  logic            go_on, take, first, do_app;
  logic [OW:0]     off_inc;
  logic [14:0]     bytes_dec;
  logic [CW-1:0]   cl_blocks;

  assign d_rdata  = desc_t'(d_rbits);
  assign d        = d_rdata;
  assign q_idx    = QIW'(item.queue);
  assign q_ok     = 32'(item.queue) < QUEUES;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;
  assign d_raddr  = (state == S_IDLE) ? QIW'(in_data.queue) : q_idx;
  assign first    = d.bytes == 15'd0;
  assign pos      = first ? '0 : OW'(32'(d.offset) + 32'(d.bytes));
  assign take     = first || pos == '0;

  always_comb begin
    state_next        = state;
    free_head_next    = free_head;
    free_count_next   = free_count;
    msg_reserved_next = msg_reserved;
    msg_left_next     = msg_left;
    msg_accepted_next = msg_accepted;
    msg_queue_next    = msg_queue;
    d_we = 1'b0; d_waddr = q_idx; d_wdata = d;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = l_raddr_q;
    b_we = 1'b0; b_waddr = '0; b_raddr = b_raddr_q;
    finish = 1'b0;
    res = '0;
    res.status = ST_OK;
    go_on = 1'b0; do_app = 1'b0;
    rest = '0; len_sum = '0; rem = '0; need = '0;
    off_inc = '0; bytes_dec = '0; cl_blocks = '0;
    unique case (state)
      S_CLR: begin
        if (32'(clr_cnt) < BLOCKS) begin
          l_we    = 1'b1;
          l_waddr = BW'(clr_cnt);
          l_wdata = (clr_cnt == '0) ? '0 : BW'(clr_cnt - 1'b1);
        end
        if (32'(clr_cnt) < QUEUES) begin
          d_we    = 1'b1;
          d_waddr = QIW'(clr_cnt);
          d_wdata = '0;
        end
        if (32'(clr_cnt) == CLR_LEN - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        res.buffered_bytes = d.bytes;
        if (!q_ok) begin
          res.status = ST_DROPPED;
          res.buffered_bytes = '0;
          finish = 1'b1;
        end else begin
          unique case (item.action)
            ACT_PUT: begin
              if (item.msg_start) begin
                free_count_next   = free_count + msg_reserved;
                msg_reserved_next = '0;
                msg_left_next     = '0;
                msg_accepted_next = 1'b0;
                if (item.message_len != 16'd0) begin
                  msg_queue_next = item.queue;
                  msg_left_next  = item.message_len;
                  len_sum = {2'b00, d.bytes} + {1'b0, item.message_len};
                  rest = (pos == '0) ? '0 : (OW+1)'(BLOCK_SIZE) - {1'b0, pos};
                  rem  = ({1'b0, item.message_len} > 17'(rest)) ?
                         {1'b0, item.message_len} - 17'(rest) : '0;
                  if (first) begin
                    rem = {1'b0, item.message_len};
                  end
                  need = (18'(rem) + 18'(BLOCK_SIZE - 1)) >> OW;
                  if (d.quota != 16'd0 && len_sum > {1'b0, d.quota}) begin
                    msg_left_next = item.message_len - 16'd1;
                    res.status    = ST_QUOTA;
                  end else if (need > 18'(free_count_next)) begin
                    msg_left_next = item.message_len - 16'd1;
                    res.status    = ST_NOBLK;
                  end else begin
                    free_count_next   = free_count_next - CW'(need);
                    msg_reserved_next = CW'(need);
                    msg_accepted_next = 1'b1;
                    go_on = 1'b1;
                  end
                end
              end else if (msg_left == 16'd0 || item.queue != msg_queue) begin
                res.status = ST_DROPPED;
              end else begin
                go_on = 1'b1;
              end
              if (go_on) begin
                msg_left_next = msg_left_next - 16'd1;
                if (!msg_accepted_next) begin
                  res.status = ST_DROPPED;
                end else if (!take) begin
                  do_app = 1'b1;
                end else if (msg_reserved_next != '0) begin
                  msg_reserved_next = msg_reserved_next - 1'b1;
                  do_app = 1'b1;
                end else if (free_count_next != '0) begin
                  free_count_next = free_count_next - 1'b1;
                  do_app = 1'b1;
                end else begin
                  res.status = ST_NOBLK;
                end
                // The last byte closes the message and frees what is left.
                if (msg_left_next == 16'd0) begin
                  free_count_next   = free_count_next + msg_reserved_next;
                  msg_reserved_next = '0;
                  msg_accepted_next = 1'b0;
                end
              end
              l_raddr = free_head;
              if (do_app) begin
                state_next = S_APPEND;
              end else begin
                finish = 1'b1;
              end
            end
            ACT_DRAIN: begin
              l_raddr = d.head;
              b_raddr = {d.head, d.offset};
              if (first) begin
                res.status = ST_EMPTY;
                finish = 1'b1;
              end else if (out_free) begin
                state_next = S_DRAIN;
              end
            end
            ACT_QUOTA: begin
              d_wdata.quota = item.quota_value;
              d_we   = out_free;
              finish = 1'b1;
            end
            default: begin
              cl_blocks = CW'((32'(d.offset) + 32'(d.bytes) + BLOCK_SIZE - 1) >> OW);
              if (!first) begin
                l_we    = out_free;
                l_waddr = d.tail;
                l_wdata = free_head;
                free_head_next  = d.head;
                free_count_next = free_count + cl_blocks;
              end
              if (msg_left != 16'd0 && msg_queue == item.queue) begin
                free_count_next   = free_count_next + msg_reserved;
                msg_reserved_next = '0;
                msg_left_next     = '0;
                msg_accepted_next = 1'b0;
              end
              d_wdata = '0;
              d_we    = out_free;
              res.buffered_bytes = '0;
              finish = 1'b1;
            end
          endcase
        end
        res.free_blocks = 9'(free_count_next);
        if (finish && out_free) begin
          state_next = S_IDLE;
        end
        // Scalar state moves only when this step really completes.
        if (!(do_app || (finish && out_free))) begin
          free_head_next    = free_head;
          free_count_next   = free_count;
          msg_reserved_next = msg_reserved;
          msg_left_next     = msg_left;
          msg_accepted_next = msg_accepted;
          msg_queue_next    = msg_queue;
        end
      end
      S_APPEND: begin
        res.buffered_bytes = d.bytes + 15'd1;
        res.free_blocks    = 9'(free_count);
        finish = 1'b1;
        d_wdata.bytes = d.bytes + 15'd1;
        b_waddr = {d.tail, pos};
        if (take) begin
          free_head_next = l_rdata;
          d_wdata.tail   = free_head;
          b_waddr        = {free_head, pos};
          if (first) begin
            d_wdata.head   = free_head;
            d_wdata.offset = '0;
          end else begin
            l_we    = out_free;
            l_waddr = d.tail;
            l_wdata = free_head;
          end
        end
        b_we = out_free;
        d_we = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end else begin
          free_head_next = free_head;
        end
      end
      S_DRAIN: begin
        off_inc   = {1'b0, d.offset} + 1'b1;
        bytes_dec = d.bytes - 15'd1;
        d_wdata.bytes  = bytes_dec;
        d_wdata.offset = OW'(off_inc);
        res.out_byte   = b_rdata;
        res.buffered_bytes = bytes_dec;
        // The head block goes back to the pool once used up or left empty.
        if (bytes_dec == 15'd0 || 32'(off_inc) >= BLOCK_SIZE) begin
          d_wdata.head   = l_rdata;
          d_wdata.offset = '0;
          l_we    = out_free;
          l_waddr = d.head;
          l_wdata = free_head;
          free_head_next  = d.head;
          free_count_next = free_count + 1'b1;
        end
        res.free_blocks = 9'(free_count_next);
        finish = 1'b1;
        d_we = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end else begin
          free_head_next  = free_head;
          free_count_next = free_count;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.queue_now_empty = res.buffered_bytes == 15'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_cnt      <= '0;
      free_head    <= BW'(BLOCKS - 1);
      free_count   <= CW'(BLOCKS);
      msg_reserved <= '0;
      msg_left     <= '0;
      msg_accepted <= 1'b0;
      msg_queue    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      free_head    <= free_head_next;
      free_count   <= free_count_next;
      msg_reserved <= msg_reserved_next;
      msg_left     <= msg_left_next;
      msg_accepted <= msg_accepted_next;
      msg_queue    <= msg_queue_next;
      if (finish && out_free && state != S_IDLE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (finish && out_free) begin
      out_data <= res;
    end
    l_raddr_q <= l_raddr;
    b_raddr_q <= b_raddr;
  end

  sbq_desc_ram #(.DEPTH(QUEUES), .AW(QIW), .DW(DSW)) u_desc (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(DSW'(d_wdata)),
    .raddr(d_raddr), .rdata(d_rbits)
  );

  sbq_link_ram #(.DEPTH(BLOCKS), .AW(BW)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  sbq_byte_ram #(.DEPTH(BLOCKS * BLOCK_SIZE), .AW(BW + OW)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(item.data_byte),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Blocks are either in a queue, reserved, or free; never more than the pool.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(free_count) + 32'(msg_reserved)) <= BLOCKS)
    else $error("free plus reserved blocks exceed the pool");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.out_byte == 8'd0 && out_data.queue_now_empty)
    else $error("empty-queue result carries data");

  a_drain_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> $past(state) == S_DESC || $past(state) == S_DRAIN)
    else $error("drain step entered without a descriptor read");

  a_no_reserve_idle: assert property (@(posedge clk) disable iff (rst)
    !msg_accepted |-> msg_reserved == '0)
    else $error("reservation held with no accepted message");

endmodule

// ===== src/sbq_desc_ram.sv =====
// ---------------------------------------------------------------------------
// sbq_desc_ram: queue descriptor memory
// One write port and one registered read port, one entry per queue.
// ---------------------------------------------------------------------------
module sbq_desc_ram import sbq_pkg::*; #(
  parameter int DEPTH = DEF_QUEUES,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sbq_link_ram.sv =====
// ---------------------------------------------------------------------------
// sbq_link_ram: block link memory
// Holds the next block of every block, for queue chains and the free list.
// ---------------------------------------------------------------------------
module sbq_link_ram import sbq_pkg::*; #(
  parameter int DEPTH = DEF_BLOCKS,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sbq_byte_ram.sv =====
// ---------------------------------------------------------------------------
// sbq_byte_ram: shared byte storage
// Every block owns BLOCK_SIZE consecutive bytes; address is block and offset.
// ---------------------------------------------------------------------------
module sbq_byte_ram import sbq_pkg::*; #(
  parameter int DEPTH = DEF_BLOCKS * DEF_BLOCK_SIZE,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
